// ===== rtl/huffman_code_bit_packer_unit_defines.svh =====
// Assertion macros shared by the checker of the Huffman bit packer.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hcbp_pkg.sv =====
// Package of the Huffman bit packer: sizes, command and register codes,
// beat payload types and the length clamp. Depends on nothing.
package hcbp_pkg;

	localparam int MAX_CODE_BITS   = 16;
	localparam int SYMBOL_COUNT    = 256;
	localparam int FIELD_CODE_BITS = 16;
	localparam int BYTE_BITS       = 8;
	localparam int LEN_W           = 5;
	localparam int SYM_W           = 8;
	localparam int SYM_AW          = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIM         = (MAX_CODE_BITS < FIELD_CODE_BITS) ?
		MAX_CODE_BITS : FIELD_CODE_BITS;
	localparam int WIN_W           = BYTE_BITS + FIELD_CODE_BITS;
	localparam int MAX_RESULTS     = 3;
	localparam int RCNT_W          = 2;
	localparam int PCNT_W          = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_ENCODE = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EOS_CODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_LENGTH = 1'd1;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [SYM_W-1:0]           symbol;
		logic [FIELD_CODE_BITS-1:0] code_value;
		logic [LEN_W-1:0]           code_len;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last;
		logic                 error;
	} out_item_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(LEN_LIM);
		return (len > lim) ? lim : len;
	endfunction

endpackage

// ===== rtl/huffman_code_bit_packer_unit.sv =====
// Huffman bit packer top level; uses hcbp_pkg. A result beat passes the table read
// stage, then the result buffer, which offers it. Throughput: one input beat per
// cycle while out_ready is high and each item yields at most one byte; otherwise
// bound by the output channel at one byte per cycle (up to three per item).
// Reset clears the length-table valid bits at once (no clearing pass), the pending
// bits, the end-of-stream registers and all handshake state.
module huffman_code_bit_packer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  hcbp_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output hcbp_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [hcbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hcbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import hcbp_pkg::*;

	logic [FIELD_CODE_BITS-1:0]         code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]                   len_mem  [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0]            entry_valid_q;

	logic [FIELD_CODE_BITS-1:0]         eos_code_q;
	logic [LEN_W-1:0]                   eos_length_q;

	logic                               valid_s1;
	logic [1:0]                         cmd_s1;
	logic                               hit_s1;
	logic [FIELD_CODE_BITS-1:0]         code_s1;
	logic [LEN_W-1:0]                   len_s1;

	logic [BYTE_BITS-1:0]               pend_byte_q;
	logic [PCNT_W-1:0]                  pend_cnt_q;

	out_item_t                          buf_q [MAX_RESULTS];
	logic [RCNT_W-1:0]                  buf_cnt_q;

	logic                               in_fire;
	logic                               out_fire;
	logic                               move_s1;
	logic                               in_range;
	logic [SYM_AW-1:0]                  addr;
	logic                               is_load;

	logic [FIELD_CODE_BITS-1:0]         seg_code;
	logic [LEN_W-1:0]                   seg_len;
	logic [LEN_W-1:0]                   shamt;
	logic [FIELD_CODE_BITS-1:0]         code_aligned;
	logic [WIN_W-1:0]                   win;
	logic [LEN_W-1:0]                   total;
	logic [RCNT_W-1:0]                  nfull;
	logic [PCNT_W-1:0]                  rem_cnt;
	logic [BYTE_BITS-1:0]               win_bytes [MAX_RESULTS];
	out_item_t                          res [MAX_RESULTS];
	logic [RCNT_W-1:0]                  res_cnt;
	logic [BYTE_BITS-1:0]               nxt_pend_byte;
	logic [PCNT_W-1:0]                  nxt_pend_cnt;

	assign in_fire  = in_valid && in_ready;
	assign out_valid = (buf_cnt_q != '0);
	assign out_data  = buf_q[0];
	assign out_fire  = out_valid && out_ready;
	assign move_s1   = valid_s1 &&
		((buf_cnt_q == '0) || ((buf_cnt_q == RCNT_W'(1)) && out_ready));
	assign in_ready  = !valid_s1 || move_s1;

	assign in_range = ({1'b0, in_data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
	assign addr     = in_data.symbol[SYM_AW-1:0];
	assign is_load  = (in_data.cmd == CMD_LOAD);

	always_ff @(posedge clk) begin
		if (in_fire && is_load && in_range) begin
			code_mem[addr] <= in_data.code_value;
			len_mem[addr]  <= clamp_len(in_data.code_len);
		end
		if (in_fire) begin
			cmd_s1  <= in_data.cmd;
			hit_s1  <= in_range && entry_valid_q[addr];
			code_s1 <= code_mem[addr];
			len_s1  <= len_mem[addr];
		end
	end

	always_comb begin
		if (cmd_s1 == CMD_FINISH) begin
			seg_code = eos_code_q;
			seg_len  = clamp_len(eos_length_q);
		end else begin
			seg_code = code_s1;
			seg_len  = hit_s1 ? len_s1 : '0;
		end
		shamt        = LEN_W'(FIELD_CODE_BITS) - seg_len;
		code_aligned = seg_code << shamt;
		win          = {pend_byte_q, {FIELD_CODE_BITS{1'b0}}} |
			({code_aligned, {BYTE_BITS{1'b0}}} >> pend_cnt_q);
		total        = LEN_W'(pend_cnt_q) + seg_len;
		nfull        = RCNT_W'(total >> PCNT_W);
		rem_cnt      = PCNT_W'(total);
		for (int i = 0; i < MAX_RESULTS; i++) begin
			win_bytes[i] = win[WIN_W-1-i*BYTE_BITS -: BYTE_BITS];
		end

		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '0;
		end
		res_cnt       = '0;
		nxt_pend_byte = pend_byte_q;
		nxt_pend_cnt  = pend_cnt_q;

		case (cmd_s1)
			CMD_ENCODE: begin
				if (seg_len == '0) begin
					res_cnt      = RCNT_W'(1);
					res[0].error = 1'b1;
				end else begin
					res_cnt       = nfull;
					for (int i = 0; i < MAX_RESULTS; i++) begin
						res[i].out_byte = win_bytes[i];
					end
					nxt_pend_byte = win_bytes[nfull];
					nxt_pend_cnt  = rem_cnt;
				end
			end
			CMD_FINISH: begin
				nxt_pend_byte = '0;
				nxt_pend_cnt  = '0;
				if (seg_len == '0) begin
					res_cnt      = RCNT_W'(1);
					res[0].last  = 1'b1;
					res[0].error = 1'b1;
				end else begin
					res_cnt = nfull + RCNT_W'(rem_cnt != '0);
					for (int i = 0; i < MAX_RESULTS; i++) begin
						res[i].out_byte = win_bytes[i];
					end
					res[res_cnt - RCNT_W'(1)].last = 1'b1;
				end
			end
			default: begin
				res_cnt = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i] <= res[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			eos_code_q    <= '0;
			eos_length_q  <= '0;
			valid_s1      <= 1'b0;
			pend_byte_q   <= '0;
			pend_cnt_q    <= '0;
			buf_cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EOS_CODE: begin
						eos_code_q <= cfg_wdata;
					end
					REG_EOS_LENGTH: begin
						eos_length_q <= cfg_wdata[LEN_W-1:0];
					end
					default: begin
						eos_code_q <= eos_code_q;
					end
				endcase
			end
			if (in_fire && is_load && in_range) begin
				entry_valid_q[addr] <= 1'b1;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				pend_byte_q <= nxt_pend_byte;
				pend_cnt_q  <= nxt_pend_cnt;
				buf_cnt_q   <= res_cnt;
			end else if (out_fire) begin
				buf_cnt_q <= buf_cnt_q - RCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/hcbp_checker.sv =====
// Port-level checker of the Huffman bit packer and its bind statement.
// Depends on hcbp_pkg and huffman_code_bit_packer_unit_defines.svh.
`include "huffman_code_bit_packer_unit_defines.svh"

module hcbp_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  hcbp_pkg::in_item_t                  in_data,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  hcbp_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [hcbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hcbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import hcbp_pkg::*;

	`HCBP_ASSERT_NOW(a_error_byte_zero, out_valid && out_data.error, out_data.out_byte == '0, "error beat carries a nonzero byte")
	`HCBP_ASSERT_NOW(a_stall_only_when_backed_up, !in_ready, out_valid, "input stalled with no result waiting")
	`HCBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")
	`HCBP_ASSERT_NEXT(a_out_drop_needs_take, out_valid && !out_ready, !$fell(out_valid), "result beat withdrawn")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);
